@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `ASSERT_PROP(lbl, clk, rst_n, !(cond))

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ sv/osp_pkg.sv @@
package osp_pkg;

    localparam int MAX_DEPTH_DEF = 8;

    localparam int COORD_W = 32;
    localparam int HALF_W  = 31;
    localparam int CTR_W   = 33;
    localparam int DIST_W  = 34;
    localparam int NODE_W  = 25;
    localparam int LEVEL_W = 4;
    localparam int TAG_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 3'd6;

    localparam logic signed [COORD_W-1:0] CENTRE_RST = '0;
    localparam logic [HALF_W-1:0]         HALF_RST   = 31'd4194304;
    localparam logic [LEVEL_W-1:0]        DEPTH_RST  = 4'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] sphere_x;
        logic signed [COORD_W-1:0] sphere_y;
        logic signed [COORD_W-1:0] sphere_z;
        logic [HALF_W-1:0]         sphere_radius;
        logic [TAG_W-1:0]          object_tag;
    } sphere_in_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node_index;
        logic [LEVEL_W-1:0] node_level;
        logic               straddles;
        logic [TAG_W-1:0]   tag_out;
    } result_out_t;

    typedef struct packed {
        logic signed [CTR_W-1:0] c;
        logic [HALF_W-1:0]       h;
    } axis_t;

    typedef struct packed {
        logic               done;
        logic               straddle;
        logic [NODE_W-1:0]  node;
        logic [LEVEL_W-1:0] level;
        axis_t [2:0]        ax;
        sphere_in_t         item;
    } stage_t;

    function automatic logic signed [COORD_W-1:0] pos_of(sphere_in_t s, int k);
        logic signed [COORD_W-1:0] p;
        unique case (k)
            0:       p = s.sphere_x;
            1:       p = s.sphere_y;
            default: p = s.sphere_z;
        endcase
        return p;
    endfunction

endpackage

@@ sv/osp_cell.sv @@
`include "assert_macros.svh"

module osp_cell #(
    parameter int LEVEL = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic [osp_pkg::LEVEL_W-1:0] limit,
    input  logic                    vld_in,
    input  osp_pkg::stage_t         st_in,
    output logic                    vld_out,
    output osp_pkg::stage_t         st_out
);
    import osp_pkg::*;

    logic                     vld_reg;
    stage_t                   st_reg;
    stage_t                   st_next;
    logic signed [DIST_W-1:0] diff [3];
    logic [DIST_W-1:0]        mag [3];
    logic [2:0]               near;
    logic [2:0]               oct;
    logic [HALF_W-1:0]        q [3];
    logic signed [COORD_W-1:0] p [3];

    always_comb
    begin
        st_next = st_in;
        for (int k = 0; k < 3; k++)
        begin
            p[k]    = pos_of(st_in.item, k);
            diff[k] = {{2{p[k][COORD_W-1]}}, p[k]}
                      - {st_in.ax[k].c[CTR_W-1], st_in.ax[k].c};
            mag[k]  = diff[k][DIST_W-1] ? DIST_W'(-diff[k]) : DIST_W'(diff[k]);
            near[k] = mag[k] <= {3'b000, st_in.item.sphere_radius};
            oct[k]  = ~diff[k][DIST_W-1];
            q[k]    = st_in.ax[k].h >> 1;
        end
        if (vld_in && !st_in.done)
        begin
            if (|near)
            begin
                st_next.done     = 1'b1;
                st_next.straddle = 1'b1;
            end
            else if (LEVEL >= int'(limit))
            begin
                st_next.done = 1'b1;
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    st_next.ax[k].c = oct[k] ? st_in.ax[k].c + {2'b00, q[k]}
                                             : st_in.ax[k].c - {2'b00, q[k]};
                    st_next.ax[k].h = q[k];
                end
                st_next.node  = {st_in.node[NODE_W-4:0], oct} + NODE_W'(1);
                st_next.level = LEVEL_W'(LEVEL + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign vld_out = vld_reg;
    assign st_out  = st_reg;

    `ASSERT_PROP(a_open_level, clk, rst_n, vld_reg && !st_reg.done |-> st_reg.level == LEVEL_W'(LEVEL + 1))
    `ASSERT_PROP(a_straddle_done, clk, rst_n, vld_reg && st_reg.straddle |-> st_reg.done)
    `ASSERT_NEVER(a_root_after_descent, clk, rst_n, vld_reg && st_reg.level != '0 && st_reg.node == '0)

endmodule

@@ sv/octree_sphere_placement.sv @@
// Octree sphere placement: one cell per tree level, one level resolved per cell.
// Result: taken from the register of the last cell in the chain.
// Throughput: one sphere per cycle; the whole chain holds while a result waits.
// Reset: chain empty, root centre 0, root half extents 64.0, depth 4.
`include "assert_macros.svh"

module octree_sphere_placement #(
    parameter int MAX_DEPTH = osp_pkg::MAX_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sphere_valid,
    output logic                              sphere_stall,
    input  osp_pkg::sphere_in_t               sphere,
    output logic                              result_valid,
    input  logic                              result_stall,
    output osp_pkg::result_out_t              result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [osp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [osp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import osp_pkg::*;

    logic signed [COORD_W-1:0] centre_reg [3];
    logic [HALF_W-1:0]         half_reg [3];
    logic [LEVEL_W-1:0]        depth_reg;
    logic [LEVEL_W-1:0]        limit;
    logic                      en;
    logic                      vld [MAX_DEPTH+2];
    stage_t                    st [MAX_DEPTH+2];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                centre_reg[k] <= CENTRE_RST;
                half_reg[k]   <= HALF_RST;
            end
            depth_reg <= DEPTH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTRE_X: centre_reg[0] <= cfg_data;
                REG_CENTRE_Y: centre_reg[1] <= cfg_data;
                REG_CENTRE_Z: centre_reg[2] <= cfg_data;
                REG_HALF_X:   half_reg[0]   <= cfg_data[HALF_W-1:0];
                REG_HALF_Y:   half_reg[1]   <= cfg_data[HALF_W-1:0];
                REG_HALF_Z:   half_reg[2]   <= cfg_data[HALF_W-1:0];
                REG_DEPTH:    depth_reg     <= cfg_data[LEVEL_W-1:0];
                default:      ;
            endcase
        end
    end

    assign limit = (int'(depth_reg) > MAX_DEPTH) ? LEVEL_W'(MAX_DEPTH) : depth_reg;

    assign en           = !(result_valid && result_stall);
    assign sphere_stall = !en;

    always_comb
    begin
        vld[0]         = sphere_valid;
        st[0].done     = 1'b0;
        st[0].straddle = 1'b0;
        st[0].node     = '0;
        st[0].level    = '0;
        for (int k = 0; k < 3; k++)
        begin
            st[0].ax[k].c = {centre_reg[k][COORD_W-1], centre_reg[k]};
            st[0].ax[k].h = half_reg[k];
        end
        st[0].item = sphere;
    end

    for (genvar l = 0; l <= MAX_DEPTH; l++)
    begin : g_cell
        osp_cell #(
            .LEVEL (l)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .limit   (limit),
            .vld_in  (vld[l]),
            .st_in   (st[l]),
            .vld_out (vld[l+1]),
            .st_out  (st[l+1])
        );
    end

    assign result_valid       = vld[MAX_DEPTH+1];
    assign result.node_index  = st[MAX_DEPTH+1].node;
    assign result.node_level  = st[MAX_DEPTH+1].level;
    assign result.straddles   = st[MAX_DEPTH+1].straddle;
    assign result.tag_out     = st[MAX_DEPTH+1].item.object_tag;

    `ASSERT_PROP(a_result_finished, clk, rst_n, result_valid |-> st[MAX_DEPTH+1].done)
    `ASSERT_PROP(a_depth_stop, clk, rst_n, result_valid && !result.straddles |-> result.node_level == limit)
    `ASSERT_NEVER(a_level_over, clk, rst_n, result_valid && result.node_level > limit)

endmodule
